// ----- rtl/core/hsim_pkg.sv -----
// ----------------------------------------------------------------------------
// hsim_pkg - shared definitions for the halo site index map
// Field widths, register indexes, stage payload types and the halo offset.
// ----------------------------------------------------------------------------
package hsim_pkg;

    localparam int HALO        = 4;

    // field widths
    localparam int CRD_W       = 11;
    localparam int SPN_W       = 11;
    localparam int GST_W       = 7;
    localparam int CNT_W       = 26;
    localparam int SITE_W      = 26;

    // stream and config port widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 26;

    // signed datapath widths
    localparam int CS_W        = CRD_W + 2;          // coord minus halo plus ghost
    localparam int HF_W        = CS_W - 1;           // halved coordinate
    localparam int WID_W       = SPN_W + 2;          // span plus both ghost layers
    localparam int SPS_W       = SPN_W + 1;          // span as signed operand
    localparam int M1_W        = HF_W + WID_W;
    localparam int M3_W        = HF_W + SPS_W;
    localparam int M5_W        = M1_W - 1 + WID_W;
    localparam int M6_W        = M3_W + SPS_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SPAN_X  = 3'd0;
    localparam t_cfg_idx CFG_SPAN_Y  = 3'd1;
    localparam t_cfg_idx CFG_SPAN_Z  = 3'd2;
    localparam t_cfg_idx CFG_GHOST_X = 3'd3;
    localparam t_cfg_idx CFG_GHOST_Y = 3'd4;
    localparam t_cfg_idx CFG_GHOST_Z = 3'd5;
    localparam t_cfg_idx CFG_LOCAL_N = 3'd6;

    // after region decode: index = p + q*w1 + ((r*w1)/2)*w2 - u*sx - ((v*sx)*sy)/2, plus local count if add_nl
    typedef struct packed {
        logic signed [CS_W-1:0]  p;
        logic signed [HF_W-1:0]  q;
        logic signed [HF_W-1:0]  r;
        logic signed [WID_W-1:0] w1;
        logic signed [WID_W-1:0] w2;
        logic signed [HF_W-1:0]  u;
        logic signed [HF_W-1:0]  v;
        logic                    inner;
        logic                    add_nl;
    } t_s1;

    typedef struct packed {
        logic signed [CS_W-1:0]  p;
        logic signed [WID_W-1:0] w2;
        logic                    add_nl;
        logic signed [M1_W-1:0]  m1;
        logic signed [M1_W-1:0]  m2;
        logic signed [M3_W-1:0]  m3;
        logic signed [M3_W-1:0]  m4;
    } t_s2;

    typedef struct packed {
        logic signed [M5_W-1:0] m5;
        logic signed [M6_W-1:0] m6;
    } t_s3;

endpackage

// ----- rtl/core/halo_site_index_map.sv -----
// ----------------------------------------------------------------------------
// halo_site_index_map - flat site index of a halo-padded lattice coordinate
// Classifies (x, y, z) into halo, ghost or interior region and evaluates the
// region's index formula in a four-stage multiply/add pipeline.
// ----------------------------------------------------------------------------
// Each input beat is registered in stages 1 to 4 before it leaves as an output beat.
// Throughput: one beat per cycle unless the output stalls; each stage holds one item and
//   moves up whenever the stage after it is empty or moving, so bubbles are squeezed out.
// Reset: clears all stage valid bits and loads spans 64, ghosts 8,
//   local count 0; no clearing pass, the block accepts beats right after reset.
module halo_site_index_map #(
    parameter int MAX_SPAN   = 1024,
    parameter int INDEX_BITS = 26
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [hsim_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hsim_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // coordinate stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [hsim_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // coord_x, coord_y, coord_z, pad
    // site index stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [hsim_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // site_index, pad
);
    import hsim_pkg::*;

    // ------------------------------------------------------------------ config
    logic [SPN_W-1:0] r_span_x, r_span_y, r_span_z;
    logic [GST_W-1:0] r_ghost_x, r_ghost_y, r_ghost_z;
    logic [CNT_W-1:0] r_local_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_x      <= SPN_W'(64);
            r_span_y      <= SPN_W'(64);
            r_span_z      <= SPN_W'(64);
            r_ghost_x     <= GST_W'(8);
            r_ghost_y     <= GST_W'(8);
            r_ghost_z     <= GST_W'(8);
            r_local_count <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SPAN_X:  r_span_x      <= i_cfg_data[SPN_W-1:0];
                CFG_SPAN_Y:  r_span_y      <= i_cfg_data[SPN_W-1:0];
                CFG_SPAN_Z:  r_span_z      <= i_cfg_data[SPN_W-1:0];
                CFG_GHOST_X: r_ghost_x     <= i_cfg_data[GST_W-1:0];
                CFG_GHOST_Y: r_ghost_y     <= i_cfg_data[GST_W-1:0];
                CFG_GHOST_Z: r_ghost_z     <= i_cfg_data[GST_W-1:0];
                CFG_LOCAL_N: r_local_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [SPN_W-1:0] sat_span(input logic [SPN_W-1:0] s);
        logic [SPN_W-1:0] res;
        if (32'(s) > MAX_SPAN) res = SPN_W'(MAX_SPAN);
        else                   res = s;
        return res;
    endfunction

    logic [SPN_W-1:0]        sx, sy, sz;
    logic signed [SPS_W-1:0] sxs, sys;

    assign sx  = sat_span(r_span_x);
    assign sy  = sat_span(r_span_y);
    assign sz  = sat_span(r_span_z);
    assign sxs = $signed({1'b0, sx});
    assign sys = $signed({1'b0, sy});

    // ------------------------------------------------------------ stage flow
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || i_m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ------------------------------------------- stage 1: region and operands
    t_s1 n_s1, r_s1;

    always_comb begin
        logic [CRD_W-1:0]        x, y, z, ym4, zm4;
        logic signed [CS_W-1:0]  xs, ys, zs, tx, ty, tz, cx, cy, cz;
        logic signed [HF_W-1:0]  x1, y1, z1, ay, az, iy1, iz1;
        logic [WID_W-2:0]        wx, wy;
        logic                    below, top, front, back, left, right;

        x = i_s_axis_tdata[CRD_W-1:0];
        y = i_s_axis_tdata[2*CRD_W-1:CRD_W];
        z = i_s_axis_tdata[3*CRD_W-1:2*CRD_W];

        xs = $signed({{(CS_W-CRD_W){1'b0}}, x});
        ys = $signed({{(CS_W-CRD_W){1'b0}}, y});
        zs = $signed({{(CS_W-CRD_W){1'b0}}, z});

        tx = xs - CS_W'(HALO) + $signed({{(CS_W-GST_W){1'b0}}, r_ghost_x});
        ty = ys - CS_W'(HALO) + $signed({{(CS_W-GST_W){1'b0}}, r_ghost_y});
        tz = zs - CS_W'(HALO) + $signed({{(CS_W-GST_W){1'b0}}, r_ghost_z});

        // halve toward zero: bump negatives by one, then drop the lsb
        cx = tx + $signed({{(CS_W-1){1'b0}}, tx[CS_W-1]});
        cy = ty + $signed({{(CS_W-1){1'b0}}, ty[CS_W-1]});
        cz = tz + $signed({{(CS_W-1){1'b0}}, tz[CS_W-1]});
        x1 = cx[CS_W-1:1];
        y1 = cy[CS_W-1:1];
        z1 = cz[CS_W-1:1];

        ay = y1 - $signed({{(HF_W-GST_W+1){1'b0}}, r_ghost_y[GST_W-1:1]});
        az = z1 - $signed({{(HF_W-GST_W+1){1'b0}}, r_ghost_z[GST_W-1:1]});

        // interior coordinates are never below the halo
        ym4 = y - CRD_W'(HALO);
        zm4 = z - CRD_W'(HALO);
        iy1 = $signed({{(HF_W-CRD_W+1){1'b0}}, ym4[CRD_W-1:1]});
        iz1 = $signed({{(HF_W-CRD_W+1){1'b0}}, zm4[CRD_W-1:1]});

        wx = {1'b0, sx} + {{(WID_W-GST_W-2){1'b0}}, r_ghost_x, 1'b0};
        wy = {1'b0, sy} + {{(WID_W-GST_W-2){1'b0}}, r_ghost_y, 1'b0};

        below = z < CRD_W'(HALO);
        top   = {1'b0, z} >= ({1'b0, sz} + (SPN_W+1)'(HALO));
        front = y < CRD_W'(HALO);
        back  = {1'b0, y} >= ({1'b0, sy} + (SPN_W+1)'(HALO));
        left  = x < CRD_W'(HALO);
        right = {1'b0, x} >= ({1'b0, sx} + (SPN_W+1)'(HALO));

        n_s1.p      = $signed({x1, x[0]});
        n_s1.q      = y1;
        n_s1.r      = z1;
        n_s1.w1     = $signed({1'b0, wx});
        n_s1.w2     = $signed({1'b0, wy});
        n_s1.u      = '0;
        n_s1.v      = '0;
        n_s1.inner  = 1'b0;
        n_s1.add_nl = 1'b1;

        if (below) begin
            n_s1.add_nl = 1'b1;
        end else if (top) begin
            n_s1.add_nl = 1'b0;
        end else if (front) begin
            n_s1.v = az;
        end else if (back) begin
            n_s1.v = az + HF_W'(1);
        end else if (left) begin
            n_s1.u = ay;
            n_s1.v = az;
        end else if (right) begin
            n_s1.u = ay + HF_W'(1);
            n_s1.v = az;
        end else begin
            n_s1.p      = xs - CS_W'(HALO);
            n_s1.q      = iy1;
            n_s1.r      = iz1;
            n_s1.w1     = $signed({{(WID_W-SPN_W){1'b0}}, sx});
            n_s1.w2     = $signed({{(WID_W-SPN_W){1'b0}}, sy});
            n_s1.inner  = 1'b1;
            n_s1.add_nl = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
    end

    // ------------------------------------------------ stage 2: first products
    t_s2 n_s2, r_s2;

    always_comb begin
        n_s2.p      = r_s1.p;
        n_s2.w2     = r_s1.w2;
        n_s2.add_nl = r_s1.add_nl;
        n_s2.m1     = M1_W'(r_s1.q) * M1_W'(r_s1.w1);
        n_s2.m2     = M1_W'(r_s1.r) * M1_W'(r_s1.w1);
        n_s2.m3     = M3_W'(r_s1.u) * M3_W'(sxs);
        n_s2.m4     = M3_W'(r_s1.v) * M3_W'(sxs);
    end

    always_ff @(posedge i_clk) begin
        if (en2) r_s2 <= n_s2;
    end

    // ----------------------------------- stage 3: second products, partial sum
    t_s3                   n_s3, r_s3;
    logic [INDEX_BITS-1:0] n_part, r_part;

    always_comb begin
        logic signed [M1_W-1:0] c2;
        logic signed [M1_W-2:0] h2;
        logic [INDEX_BITS-1:0]  nl;

        c2 = r_s2.m2 + $signed({{(M1_W-1){1'b0}}, r_s2.m2[M1_W-1]});
        h2 = c2[M1_W-1:1];
        nl = r_s2.add_nl ? INDEX_BITS'(r_local_count) : '0;

        n_s3.m5 = M5_W'(h2) * M5_W'(r_s2.w2);
        n_s3.m6 = M6_W'(r_s2.m4) * M6_W'(sys);
        n_part  = INDEX_BITS'(r_s2.p) + INDEX_BITS'(r_s2.m1)
                - INDEX_BITS'(r_s2.m3) + nl;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3   <= n_s3;
            r_part <= n_part;
        end
    end

    // ------------------------------------------------- stage 4: final sum
    logic [SITE_W-1:0] n_site, r_site;

    always_comb begin
        logic signed [M6_W-1:0] c6;
        logic signed [M6_W-2:0] h6;
        logic [INDEX_BITS-1:0]  sum;

        c6  = r_s3.m6 + $signed({{(M6_W-1){1'b0}}, r_s3.m6[M6_W-1]});
        h6  = c6[M6_W-1:1];
        sum = r_part + INDEX_BITS'(r_s3.m5) - INDEX_BITS'(h6);
        n_site = SITE_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (en4) r_site <= n_site;
    end

    assign o_m_axis_tdata = {{(OUT_TDATA_W-SITE_W){1'b0}}, r_site};

    // ------------------------------------------------------------ assertions
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v1)
        else $error("accepted beat did not reach stage 1");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en4) |=> (r_v3 && $stable(r_part) && $stable(r_s3)))
        else $error("stage 3 item changed during stall");

    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled with a bubble in the pipeline");

    a_inner_no_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_s1.inner) |-> (r_s1.u == '0 && r_s1.v == '0 && !r_s1.add_nl))
        else $error("interior site carries a ghost correction");

endmodule
